[hw/rtl/bnse_pkg.sv]
package bnse_pkg;

  // display thresholds, signed tenths
  localparam logic signed [15:0] HI_LIMIT   = 16'sd19995;
  localparam logic signed [15:0] LO_LIMIT   = -16'sd995;
  localparam logic signed [15:0] POINT_HIGH = 16'sd1995;
  localparam logic signed [15:0] POINT_LOW  = -16'sd95;

  // x * RECIP10 >> RECIP_SHIFT == x / 10 for x below 81920
  // x * RECIP100 >> RECIP_SHIFT == x / 100 for x below 2048
  localparam logic [15:0] RECIP10     = 16'd52429;
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [3:0] ROUND_LIMIT = 4'd5;

  // fixed glyph bytes for the out-of-range patterns
  localparam logic [7:0] HI_BYTE0 = 8'h10;
  localparam logic [7:0] HI_BYTE1 = 8'h09;
  localparam logic [7:0] HI_BYTE2 = 8'hC3;
  localparam logic [7:0] HI_BYTE3 = 8'hF0;
  localparam logic [7:0] LO_BYTE0 = 8'h30;
  localparam logic [7:0] LO_BYTE1 = 8'h39;
  localparam logic [7:0] LO_BYTE2 = 8'h38;
  localparam logic [7:0] LO_BYTE3 = 8'hE0;

  localparam logic [7:0] MINUS_BIT = 8'h40;
  localparam logic [7:0] POINT_BIT = 8'h10;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_HI,
    KIND_LO
  } kind_t;

  // shown number and its split, ahead of the glyph stage
  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic        point;
    logic [10:0] shown;
    logic [7:0]  div10;
    logic [4:0]  div100;
  } digit_word_t;

  typedef struct packed {
    logic [7:0] left_a;
    logic [7:0] left_b;
    logic [7:0] mid_a;
    logic [7:0] mid_b;
    logic [7:0] right_a;
    logic [7:0] right_b;
    logic       lead;
  } seg_word_t;

  function automatic logic [7:0] glyph_a(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hBF;
      4'd1:    g = 8'h00;
      4'd2:    g = 8'hF7;
      4'd3:    g = 8'hF1;
      4'd4:    g = 8'h5C;
      4'd5:    g = 8'hFD;
      4'd6:    g = 8'hFF;
      4'd7:    g = 8'h90;
      4'd8:    g = 8'hFF;
      4'd9:    g = 8'hFD;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] glyph_b(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h07;
      4'd1:    g = 8'h07;
      4'd2:    g = 8'h06;
      4'd3:    g = 8'h07;
      4'd4:    g = 8'h07;
      4'd5:    g = 8'h03;
      4'd6:    g = 8'h03;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h07;
      4'd9:    g = 8'h07;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

[hw/rtl/bnse_glyphs.sv]
module bnse_glyphs (
  input  bnse_pkg::digit_word_t w,
  output bnse_pkg::seg_word_t   seg
);

  logic [3:0] tens10_lo;
  logic [3:0] units10_lo;
  logic [3:0] units;
  logic [3:0] tens;
  logic [4:0] hund_wide;
  logic [3:0] hund;
  logic       show_hund;

  // low nibble of 10*q, enough since the remainder is below 10
  assign units10_lo = {w.div10[0], 3'b000} + {w.div10[2:0], 1'b0};
  assign tens10_lo  = {w.div100[0], 3'b000} + {w.div100[2:0], 1'b0};
  assign units      = w.shown[3:0] - units10_lo;
  assign tens       = w.div10[3:0] - tens10_lo;

  always_comb begin
    if (w.div100 >= 5'd20) begin
      hund_wide = w.div100 - 5'd20;
    end else if (w.div100 >= 5'd10) begin
      hund_wide = w.div100 - 5'd10;
    end else begin
      hund_wide = w.div100;
    end
  end
  assign hund      = hund_wide[3:0];
  assign show_hund = (w.shown > 11'd99);

  always_comb begin
    seg = '0;
    case (w.kind)
      bnse_pkg::KIND_HI: begin
        seg.left_a = bnse_pkg::HI_BYTE0;
        seg.left_b = bnse_pkg::HI_BYTE1;
        seg.mid_a  = bnse_pkg::HI_BYTE2;
        seg.mid_b  = bnse_pkg::HI_BYTE3;
      end
      bnse_pkg::KIND_LO: begin
        seg.left_a = bnse_pkg::LO_BYTE0;
        seg.left_b = bnse_pkg::LO_BYTE1;
        seg.mid_a  = bnse_pkg::LO_BYTE2;
        seg.mid_b  = bnse_pkg::LO_BYTE3;
      end
      bnse_pkg::KIND_NUM: begin
        seg.left_a  = (w.neg ? bnse_pkg::MINUS_BIT : 8'h00)
                    | (show_hund ? bnse_pkg::glyph_a(hund) : 8'h00);
        seg.left_b  = show_hund ? bnse_pkg::glyph_b(hund) : 8'h00;
        // tens is zero anyway below ten, which gives the forced zero
        seg.mid_a   = bnse_pkg::glyph_a(tens);
        seg.mid_b   = bnse_pkg::glyph_b(tens)
                    | (w.point ? bnse_pkg::POINT_BIT : 8'h00);
        seg.right_a = bnse_pkg::glyph_a(units);
        seg.right_b = bnse_pkg::glyph_b(units);
        seg.lead    = (w.shown > 11'd999);
      end
      default: seg = '0;
    endcase
  end

endmodule

[hw/rtl/big_number_segment_encoder.sv]
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | value_tenths
// out     | out of    | out_valid/out_stall| left/mid/right_byte_a/b, leading_one
//
// five register stages; one word enters per cycle while in_stall is low and
// raises out_valid at the output register; the chain sets throughput, one a cycle
// rst clears every stage valid; payload registers are not reset
// out_stall holds the output register; stages behind it keep filling until
// the chain is full, and then in_stall goes high
module big_number_segment_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  value_tenths,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          left_byte_a,
  output logic [7:0]          left_byte_b,
  output logic [7:0]          mid_byte_a,
  output logic [7:0]          mid_byte_b,
  output logic [7:0]          right_byte_a,
  output logic [7:0]          right_byte_b,
  output logic                leading_one
);

  // stage 1: input word
  logic               s1_valid;
  logic signed [15:0] s1_value;
  // stage 2: class, magnitude, magnitude / 10
  logic               s2_valid;
  bnse_pkg::kind_t    s2_kind;
  logic               s2_neg;
  logic               s2_point;
  logic [14:0]        s2_mag;
  logic [10:0]        s2_quot;
  // stage 3: shown number
  logic               s3_valid;
  bnse_pkg::kind_t    s3_kind;
  logic               s3_neg;
  logic               s3_point;
  logic [10:0]        s3_shown;
  // stage 4: digit split
  logic                   s4_valid;
  bnse_pkg::digit_word_t  s4_word;
  // output
  bnse_pkg::seg_word_t    seg_next;
  bnse_pkg::seg_word_t    seg;

  logic out_en, s4_en, s3_en, s2_en, s1_en;

  assign out_en   = !out_valid || !out_stall;
  assign s4_en    = !s4_valid || out_en;
  assign s3_en    = !s3_valid || s4_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  // stage 1 -> 2
  bnse_pkg::kind_t kind_next;
  logic [15:0]     neg_value;
  logic [14:0]     mag_next;
  logic [30:0]     prod_mag;

  always_comb begin
    if (s1_value > bnse_pkg::HI_LIMIT) begin
      kind_next = bnse_pkg::KIND_HI;
    end else if (s1_value < bnse_pkg::LO_LIMIT) begin
      kind_next = bnse_pkg::KIND_LO;
    end else begin
      kind_next = bnse_pkg::KIND_NUM;
    end
  end

  assign neg_value = 16'(-s1_value);
  assign mag_next  = s1_value[15] ? neg_value[14:0] : s1_value[14:0];
  assign prod_mag  = {16'd0, mag_next} * {15'd0, bnse_pkg::RECIP10};

  // stage 2 -> 3
  logic [3:0]  quot10_lo;
  logic [3:0]  rem;
  logic [10:0] shown_next;

  assign quot10_lo  = {s2_quot[0], 3'b000} + {s2_quot[2:0], 1'b0};
  assign rem        = s2_mag[3:0] - quot10_lo;
  // round up only when the remainder is above five
  assign shown_next = s2_point ? s2_mag[10:0]
                               : s2_quot + {10'd0, (rem > bnse_pkg::ROUND_LIMIT)};

  // stage 3 -> 4
  logic [26:0] prod_10;
  logic [23:0] prod_100;

  assign prod_10  = {16'd0, s3_shown} * {11'd0, bnse_pkg::RECIP10};
  assign prod_100 = {13'd0, s3_shown} * {11'd0, bnse_pkg::RECIP100};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (s3_en) begin
        s3_valid <= s2_valid;
      end
      if (s4_en) begin
        s4_valid <= s3_valid;
      end
      if (out_en) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_value <= value_tenths;
    end
    if (s2_en && s1_valid) begin
      s2_kind  <= kind_next;
      s2_neg   <= s1_value[15];
      s2_point <= (s1_value <= bnse_pkg::POINT_HIGH) && (s1_value >= bnse_pkg::POINT_LOW);
      s2_mag   <= mag_next;
      s2_quot  <= prod_mag[bnse_pkg::RECIP_SHIFT +: 11];
    end
    if (s3_en && s2_valid) begin
      s3_kind  <= s2_kind;
      s3_neg   <= s2_neg;
      s3_point <= s2_point;
      s3_shown <= shown_next;
    end
    if (s4_en && s3_valid) begin
      s4_word.kind   <= s3_kind;
      s4_word.neg    <= s3_neg;
      s4_word.point  <= s3_point;
      s4_word.shown  <= s3_shown;
      s4_word.div10  <= prod_10[bnse_pkg::RECIP_SHIFT +: 8];
      s4_word.div100 <= prod_100[bnse_pkg::RECIP_SHIFT +: 5];
    end
    if (out_en && s4_valid) begin
      seg <= seg_next;
    end
  end

  bnse_glyphs u_glyphs (
    .w   (s4_word),
    .seg (seg_next)
  );

  assign left_byte_a  = seg.left_a;
  assign left_byte_b  = seg.left_b;
  assign mid_byte_a   = seg.mid_a;
  assign mid_byte_b   = seg.mid_b;
  assign right_byte_a = seg.right_a;
  assign right_byte_b = seg.right_b;
  assign leading_one  = seg.lead;

endmodule

[hw/rtl/bnse_checker.sv]
module bnse_props (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] left_byte_a,
  input logic [7:0] left_byte_b,
  input logic [7:0] mid_byte_a,
  input logic [7:0] mid_byte_b,
  input logic [7:0] right_byte_a,
  input logic [7:0] right_byte_b,
  input logic       leading_one
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid
      && $stable({left_byte_a, left_byte_b, mid_byte_a, mid_byte_b,
                  right_byte_a, right_byte_b, leading_one}))
    else $error("output word changed while stalled");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a shown thousand always lights the hundreds digit
  a_lead_hund: assert property (@(posedge clk) disable iff (rst)
    out_valid && leading_one |-> left_byte_b != 8'h00)
    else $error("leading one without hundreds digit");

  // blank units means Hi or Lo, which never lights the leading one
  a_blank_units: assert property (@(posedge clk) disable iff (rst)
    out_valid && right_byte_b == 8'h00 |-> !leading_one && right_byte_a == 8'h00)
    else $error("partial units digit or leading one on fixed pattern");

endmodule

bind big_number_segment_encoder bnse_props u_bnse_props (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .left_byte_a  (left_byte_a),
  .left_byte_b  (left_byte_b),
  .mid_byte_a   (mid_byte_a),
  .mid_byte_b   (mid_byte_b),
  .right_byte_a (right_byte_a),
  .right_byte_b (right_byte_b),
  .leading_one  (leading_one)
);

[dv/bnse_checker.sv]
`timescale 1ns / 1ps

module bnse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] value_tenths,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         left_byte_a,
  input  logic [7:0]         left_byte_b,
  input  logic [7:0]         mid_byte_a,
  input  logic [7:0]         mid_byte_b,
  input  logic [7:0]         right_byte_a,
  input  logic [7:0]         right_byte_b,
  input  logic               leading_one,
  output int                 errors,
  output int                 pending
);

  // digit glyphs, digit 9 in the top byte
  localparam logic [79:0] SEG_A_TAB = {
    8'hFD, 8'hFF, 8'h90, 8'hFF, 8'hFD, 8'h5C, 8'hF1, 8'hF7, 8'h00, 8'hBF
  };
  localparam logic [79:0] SEG_B_TAB = {
    8'h07, 8'h07, 8'h07, 8'h03, 8'h03, 8'h07, 8'h07, 8'h06, 8'h07, 8'h07
  };

  bnse_pkg::seg_word_t expected_segs[$];

  function automatic bnse_pkg::seg_word_t encode_reading(input logic signed [15:0] v);
    bnse_pkg::seg_word_t s;
    int                  r;
    int                  m;
    int                  d;
    s = '0;
    r = v;
    if (r > 19995) begin
      s.left_a = 8'h10;
      s.left_b = 8'h09;
      s.mid_a  = 8'hC3;
      s.mid_b  = 8'hF0;
    end else if (r < -995) begin
      s.left_a = 8'h30;
      s.left_b = 8'h39;
      s.mid_a  = 8'h38;
      s.mid_b  = 8'hE0;
    end else begin
      if (r < 0) begin
        m = -r;
        s.left_a = 8'h40;
      end else begin
        m = r;
      end
      // outside the point window: whole units, round up only above 5
      if (r > 1995 || r < -95) begin
        m = m / 10 + ((m % 10) > 5 ? 1 : 0);
      end else begin
        s.mid_b = s.mid_b | 8'h10;
      end
      s.lead = (m > 999);
      if (m > 99) begin
        d = (m / 100) % 10;
        s.left_a = s.left_a | SEG_A_TAB[d*8 +: 8];
        s.left_b = s.left_b | SEG_B_TAB[d*8 +: 8];
      end
      // tens digit shows a zero below ten
      d = (m > 9) ? (m / 10) % 10 : 0;
      s.mid_a = s.mid_a | SEG_A_TAB[d*8 +: 8];
      s.mid_b = s.mid_b | SEG_B_TAB[d*8 +: 8];
      d = m % 10;
      s.right_a = SEG_A_TAB[d*8 +: 8];
      s.right_b = SEG_B_TAB[d*8 +: 8];
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input logic signed [15:0] src);
    if (got != want)
      report_mismatch($sformatf("%s got %02h want %02h for reading %0d",
                                name, got, want, src));
  endtask

  logic signed [15:0] src_q[$];

  always @(posedge clk) begin : watch
    bnse_pkg::seg_word_t want;
    logic signed [15:0]  src;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_segs.push_back(encode_reading(value_tenths));
        src_q.push_back(value_tenths);
      end
      if (out_valid && !out_stall) begin
        if (expected_segs.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = expected_segs.pop_front();
          src  = src_q.pop_front();
          check_field("left_byte_a", left_byte_a, want.left_a, src);
          check_field("left_byte_b", left_byte_b, want.left_b, src);
          check_field("mid_byte_a", mid_byte_a, want.mid_a, src);
          check_field("mid_byte_b", mid_byte_b, want.mid_b, src);
          check_field("right_byte_a", right_byte_a, want.right_a, src);
          check_field("right_byte_b", right_byte_b, want.right_b, src);
          check_field("leading_one", leading_one, want.lead, src);
        end
      end
      pending <= expected_segs.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] value_tenths = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         left_byte_a;
  logic [7:0]         left_byte_b;
  logic [7:0]         mid_byte_a;
  logic [7:0]         mid_byte_b;
  logic [7:0]         right_byte_a;
  logic [7:0]         right_byte_b;
  logic               leading_one;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  int                 words_sent = 0;
  bit                 idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  big_number_segment_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value_tenths(value_tenths),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_byte_a(left_byte_a), .left_byte_b(left_byte_b),
    .mid_byte_a(mid_byte_a), .mid_byte_b(mid_byte_b),
    .right_byte_a(right_byte_a), .right_byte_b(right_byte_b),
    .leading_one(leading_one)
  );

  bnse_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value_tenths(value_tenths),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_byte_a(left_byte_a), .left_byte_b(left_byte_b),
    .mid_byte_a(mid_byte_a), .mid_byte_b(mid_byte_b),
    .right_byte_a(right_byte_a), .right_byte_b(right_byte_b),
    .leading_one(leading_one),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_on || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic signed [15:0] v);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    value_tenths <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic signed [15:0] random_reading();
    int p;
    int base;
    int edges[13];
    edges = '{19995, -995, 1995, -95, 0, 9, 10, 99, 100, 999, 1000, -10, -100};
    p = $urandom_range(0, 99);
    if (p < 25) return 16'($urandom);
    if (p < 45) begin
      base = edges[$urandom_range(0, 12)];
      return 16'(base + $urandom_range(0, 20) - 10);
    end
    if (p < 75) return 16'($urandom_range(0, 21200) - 1100);
    return 16'($urandom_range(0, 2300) - 200);
  endfunction

  // directed readings: range ends, thresholds, rounding and digit blanking
  logic signed [15:0] directed[25] = '{
    16'sd32767, -16'sd32768, 16'sd19995, 16'sd19996, -16'sd995, -16'sd996,
    16'sd1995, 16'sd1996, -16'sd95, -16'sd96, 16'sd0, 16'sd9, 16'sd10,
    16'sd99, 16'sd100, 16'sd999, 16'sd1000, -16'sd1, -16'sd9, -16'sd10,
    16'sd2005, 16'sd2006, 16'sd19994, -16'sd106, -16'sd100
  };

  // sender
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_word(random_reading());
    end
    in_valid <= 1'b0;
    // pending is updated at the edge, so wait for the next edge before reading it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // receiver: stall runs of random length, one long hold-off to back up the chain
  initial begin : receiver
    int  n;
    int  p;
    bit  held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && words_sent >= 500) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        p = $urandom_range(0, 99);
        n = (p < 60) ? $urandom_range(1, 2) : (p < 90) ? $urandom_range(3, 8)
          : $urandom_range(20, 50);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      p = $urandom_range(0, 99);
      n = (p < 50) ? $urandom_range(1, 3) : (p < 90) ? $urandom_range(4, 15)
        : $urandom_range(50, 150);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
    end
  end

endmodule
